// ----- sv/nested_angle_group_scanner_assert.svh -----
// ----------------------------------------------------------------------------
// Nested angle group scanner assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NESTED_ANGLE_GROUP_SCANNER_ASSERT_SVH
`define NESTED_ANGLE_GROUP_SCANNER_ASSERT_SVH

// The expression holds at every clock edge out of reset.
`define NAGS_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("nested angle group scanner: invariant violated");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define NAGS_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nested angle group scanner: implication violated");

`endif

// ----- sv/nags_pkg.sv -----
// ----------------------------------------------------------------------------
// Nested angle group scanner package
// Sizes, character class codes and the structs passed between the parts.
// ----------------------------------------------------------------------------
`default_nettype none

package nags_pkg;

   localparam int STACK_DEPTH  = 64;
   localparam int STACK_ADDR_W = $clog2(STACK_DEPTH);
   localparam int DEPTH_W      = $clog2(STACK_DEPTH + 1);
   localparam int CHAR_W       = 21;
   localparam int COUNT_W      = 16;

   typedef logic [4:0] cls_type;

   localparam cls_type CLS_OTHER    = 5'd0;
   localparam cls_type CLS_BLANK    = 5'd1;
   localparam cls_type CLS_NEWLINE  = 5'd2;
   localparam cls_type CLS_EOI      = 5'd3;
   localparam cls_type CLS_LT       = 5'd4;
   localparam cls_type CLS_GT       = 5'd5;
   localparam cls_type CLS_EQ       = 5'd6;
   localparam cls_type CLS_LPAREN   = 5'd7;
   localparam cls_type CLS_LBRACKET = 5'd8;
   localparam cls_type CLS_LBRACE   = 5'd9;
   localparam cls_type CLS_RPAREN   = 5'd10;
   localparam cls_type CLS_RBRACKET = 5'd11;
   localparam cls_type CLS_RBRACE   = 5'd12;
   localparam cls_type CLS_SQUOTE   = 5'd13;
   localparam cls_type CLS_DQUOTE   = 5'd14;
   localparam cls_type CLS_BTICK    = 5'd15;
   localparam cls_type CLS_BACKSL   = 5'd16;
   localparam cls_type CLS_DOLLAR   = 5'd17;

   typedef struct packed {
      logic    start;
      logic    wanted;
      cls_type cls;
   } item_type;

   typedef struct packed {
      logic               accepted;
      logic [COUNT_W-1:0] group_length;
      logic [COUNT_W-1:0] blanks_skipped;
   } rsp_type;

   typedef struct packed {
      logic               fire;
      logic               consume;
      logic               emit;
      logic [DEPTH_W-1:0] depth;
   } back_status_type;

endpackage

`default_nettype wire

// ----- sv/nags_front.sv -----
// ----------------------------------------------------------------------------
// Nested angle group scanner front end
// Reduces each incoming character to a small class code for the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

module nags_front
   import nags_pkg::*;
(
   input  logic [CHAR_W-1:0] character,
   input  logic              start_scan,
   input  logic              token_wanted,
   input  logic              end_of_input,
   output item_type          item
);

   localparam logic [CHAR_W-1:0] CHAR_TAB      = CHAR_W'(9);
   localparam logic [CHAR_W-1:0] CHAR_LF       = CHAR_W'(10);
   localparam logic [CHAR_W-1:0] CHAR_CR       = CHAR_W'(13);
   localparam logic [CHAR_W-1:0] CHAR_SPACE    = CHAR_W'(32);
   localparam logic [CHAR_W-1:0] CHAR_DQUOTE   = CHAR_W'(34);
   localparam logic [CHAR_W-1:0] CHAR_DOLLAR   = CHAR_W'(36);
   localparam logic [CHAR_W-1:0] CHAR_SQUOTE   = CHAR_W'(39);
   localparam logic [CHAR_W-1:0] CHAR_LPAREN   = CHAR_W'(40);
   localparam logic [CHAR_W-1:0] CHAR_RPAREN   = CHAR_W'(41);
   localparam logic [CHAR_W-1:0] CHAR_LT       = CHAR_W'(60);
   localparam logic [CHAR_W-1:0] CHAR_EQ       = CHAR_W'(61);
   localparam logic [CHAR_W-1:0] CHAR_GT       = CHAR_W'(62);
   localparam logic [CHAR_W-1:0] CHAR_LBRACKET = CHAR_W'(91);
   localparam logic [CHAR_W-1:0] CHAR_BACKSL   = CHAR_W'(92);
   localparam logic [CHAR_W-1:0] CHAR_RBRACKET = CHAR_W'(93);
   localparam logic [CHAR_W-1:0] CHAR_BTICK    = CHAR_W'(96);
   localparam logic [CHAR_W-1:0] CHAR_LBRACE   = CHAR_W'(123);
   localparam logic [CHAR_W-1:0] CHAR_RBRACE   = CHAR_W'(125);

   cls_type cls;

   always_comb begin
      if (end_of_input) begin
         cls = CLS_EOI;
      end else begin
         case (character)
            CHAR_SPACE, CHAR_TAB: cls = CLS_BLANK;
            CHAR_LF, CHAR_CR:     cls = CLS_NEWLINE;
            CHAR_LT:              cls = CLS_LT;
            CHAR_GT:              cls = CLS_GT;
            CHAR_EQ:              cls = CLS_EQ;
            CHAR_LPAREN:          cls = CLS_LPAREN;
            CHAR_LBRACKET:        cls = CLS_LBRACKET;
            CHAR_LBRACE:          cls = CLS_LBRACE;
            CHAR_RPAREN:          cls = CLS_RPAREN;
            CHAR_RBRACKET:        cls = CLS_RBRACKET;
            CHAR_RBRACE:          cls = CLS_RBRACE;
            CHAR_SQUOTE:          cls = CLS_SQUOTE;
            CHAR_DQUOTE:          cls = CLS_DQUOTE;
            CHAR_BTICK:           cls = CLS_BTICK;
            CHAR_BACKSL:          cls = CLS_BACKSL;
            CHAR_DOLLAR:          cls = CLS_DOLLAR;
            default:              cls = CLS_OTHER;
         endcase
      end
   end

   assign item = '{start: start_scan, wanted: token_wanted, cls: cls};

endmodule

`default_nettype wire

// ----- sv/nags_item_queue.sv -----
// ----------------------------------------------------------------------------
// Nested angle group scanner item queue
// Two-entry queue of classified items between the front end and the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

module nags_item_queue
   import nags_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type wr_data,
   output logic     full,
   output logic     valid,
   output item_type rd_data,
   input  logic     pop
);

   item_type   data_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   always_comb begin
      full      = (count_ff == 2'd2);
      valid     = (count_ff != 2'd0);
      do_push   = push && !full;
      do_pop    = pop && valid;
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
      rd_data = data_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- sv/nags_back.sv -----
// ----------------------------------------------------------------------------
// Nested angle group scanner back end
// Runs the scan FSM and the closer stack, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module nags_back
   import nags_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            item_valid,
   input  item_type        item,
   output logic            item_pop,
   input  logic            rsp_full,
   output logic            rsp_push,
   output rsp_type         rsp,
   output back_status_type status
);

   localparam logic [1:0] PH_DONE     = 2'd0;
   localparam logic [1:0] PH_BLANKS   = 2'd1;
   localparam logic [1:0] PH_AFTER_LT = 2'd2;
   localparam logic [1:0] PH_BODY     = 2'd3;

   localparam logic [1:0] Q_NONE   = 2'd0;
   localparam logic [1:0] Q_SINGLE = 2'd1;
   localparam logic [1:0] Q_DOUBLE = 2'd2;
   localparam logic [1:0] Q_BACK   = 2'd3;

   localparam logic [2:0] D_NONE   = 3'd0;
   localparam logic [2:0] D_ESCAPE = 3'd1;
   localparam logic [2:0] D_DOLLAR = 3'd2;
   localparam logic [2:0] D_EQ     = 3'd3;
   localparam logic [2:0] D_LT     = 3'd4;
   localparam logic [2:0] D_GT     = 3'd5;

   localparam logic [2:0] CL_ANGLE  = 3'd0;
   localparam logic [2:0] CL_PAREN  = 3'd1;
   localparam logic [2:0] CL_SQUARE = 3'd2;
   localparam logic [2:0] CL_BRACE  = 3'd3;
   localparam logic [2:0] CL_INTERP = 3'd4;

   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_PUSH  = 2'd1;
   localparam logic [1:0] OP_CLOSE = 2'd2;

   localparam logic [1:0] GO_ON     = 2'd0;
   localparam logic [1:0] GO_REJECT = 2'd1;
   localparam logic [1:0] GO_ACCEPT = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
   endfunction

   logic [1:0]         phase_ff, phase_in;
   logic [1:0]         quote_ff, quote_in;
   logic [2:0]         defer_ff, defer_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [COUNT_W-1:0] length_ff, length_in;
   logic [COUNT_W-1:0] blank_ff, blank_in;
   logic [2:0]         top_ff, top_in;
   logic [2:0]         below_ff;
   logic [2:0]         stack_mem [STACK_DEPTH];

   logic               fire;
   logic               consume;
   logic               emit;
   logic [1:0]         res;
   logic [1:0]         op_res;
   cls_type            cls;
   cls_type            quote_cls;
   logic               is_bracket;

   logic               item_reject;
   logic [COUNT_W-1:0] item_length;
   logic [1:0]         item_quote;
   logic [2:0]         item_defer;
   logic [1:0]         item_op;
   logic [2:0]         item_code;

   logic [1:0]         op;
   logic [2:0]         op_code;
   logic               use_item;
   logic               item_late;
   logic               split;
   logic               init;
   logic               clear;
   logic [DEPTH_W-1:0] d_eff;
   logic [2:0]         t_eff;
   logic               wr_en;
   logic [STACK_ADDR_W-1:0] wr_addr;
   logic               rd_en;
   logic [STACK_ADDR_W-1:0] rd_addr;

   assign fire = item_valid && !rsp_full;
   assign cls  = item.cls;

   always_comb begin
      case (quote_ff)
         Q_SINGLE: quote_cls = CLS_SQUOTE;
         Q_DOUBLE: quote_cls = CLS_DQUOTE;
         default:  quote_cls = CLS_BTICK;
      endcase
      is_bracket = cls inside {CLS_LPAREN, CLS_LBRACKET, CLS_LBRACE,
                               CLS_RPAREN, CLS_RBRACKET, CLS_RBRACE};

      // Effect of the item as an ordinary body character.
      item_reject = (cls == CLS_EOI) || (cls == CLS_NEWLINE);
      item_length = sat_inc(length_ff);
      item_quote  = quote_ff;
      item_defer  = D_NONE;
      item_op     = OP_NONE;
      item_code   = CL_ANGLE;
      if (quote_ff != Q_NONE) begin
         if (cls == CLS_BACKSL) begin
            item_defer = D_ESCAPE;
         end else if (cls == quote_cls) begin
            item_quote = Q_NONE;
         end else if (quote_ff == Q_BACK && cls == CLS_DOLLAR) begin
            item_defer = D_DOLLAR;
         end
      end else begin
         case (cls)
            CLS_SQUOTE:   item_quote = Q_SINGLE;
            CLS_DQUOTE:   item_quote = Q_DOUBLE;
            CLS_BTICK:    item_quote = Q_BACK;
            CLS_EQ:       item_defer = D_EQ;
            CLS_LT:       item_defer = D_LT;
            CLS_GT:       item_defer = D_GT;
            CLS_LPAREN:   begin item_op = OP_PUSH;  item_code = CL_PAREN;  end
            CLS_LBRACKET: begin item_op = OP_PUSH;  item_code = CL_SQUARE; end
            CLS_LBRACE:   begin item_op = OP_PUSH;  item_code = CL_BRACE;  end
            CLS_RPAREN:   begin item_op = OP_CLOSE; item_code = CL_PAREN;  end
            CLS_RBRACKET: begin item_op = OP_CLOSE; item_code = CL_SQUARE; end
            CLS_RBRACE:   begin item_op = OP_CLOSE; item_code = CL_BRACE;  end
            default:      ;
         endcase
      end

      phase_in  = phase_ff;
      quote_in  = quote_ff;
      defer_in  = defer_ff;
      length_in = length_ff;
      blank_in  = blank_ff;
      res       = GO_ON;
      op        = OP_NONE;
      op_code   = CL_ANGLE;
      use_item  = 1'b0;
      item_late = 1'b0;
      split     = 1'b0;
      init      = 1'b0;
      clear     = 1'b0;

      if (item.start && !item.wanted) begin
         clear = 1'b1;
         res   = GO_REJECT;
      end else if (item.start || phase_ff == PH_BLANKS) begin
         clear = item.start;
         if (item.start) begin
            length_in = '0;
            blank_in  = '0;
            quote_in  = Q_NONE;
            defer_in  = D_NONE;
         end
         if (cls == CLS_BLANK) begin
            blank_in = sat_inc(blank_in);
            phase_in = PH_BLANKS;
         end else if (cls == CLS_LT) begin
            length_in = COUNT_W'(1);
            phase_in  = PH_AFTER_LT;
         end else begin
            res = GO_REJECT;
         end
      end else begin
         case (phase_ff)
            PH_AFTER_LT: begin
               if (cls == CLS_EOI || cls == CLS_EQ) begin
                  res = GO_REJECT;
               end else begin
                  phase_in = PH_BODY;
                  quote_in = Q_NONE;
                  defer_in = D_NONE;
                  init     = 1'b1;
                  use_item = 1'b1;
               end
            end
            PH_BODY: begin
               defer_in = D_NONE;
               case (defer_ff)
                  D_ESCAPE: begin
                     if (item_reject) begin
                        res = GO_REJECT;
                     end else begin
                        length_in = item_length;
                     end
                  end
                  D_DOLLAR: begin
                     if (cls == CLS_LBRACE) begin
                        length_in = item_length;
                        quote_in  = Q_NONE;
                        op        = OP_PUSH;
                        op_code   = CL_INTERP;
                     end else begin
                        use_item = 1'b1;
                     end
                  end
                  D_EQ: begin
                     if (cls == CLS_GT) begin
                        length_in = item_length;
                     end else begin
                        use_item = 1'b1;
                     end
                  end
                  D_LT, D_GT: begin
                     if (cls == CLS_EQ) begin
                        length_in = item_length;
                     end else begin
                        op      = (defer_ff == D_LT) ? OP_PUSH : OP_CLOSE;
                        op_code = CL_ANGLE;
                        if (is_bracket) begin
                           split = 1'b1;
                        end else begin
                           item_late = 1'b1;
                        end
                     end
                  end
                  default: use_item = 1'b1;
               endcase
            end
            default: ;
         endcase
      end

      // Item effects that come before its own stack operation.
      if (use_item) begin
         length_in = item_length;
         quote_in  = item_quote;
         defer_in  = item_defer;
         op        = item_op;
         op_code   = item_code;
         if (item_reject) begin
            res = GO_REJECT;
         end
      end

      // Single stack operation of the cycle.
      d_eff   = init ? DEPTH_W'(1) : depth_ff;
      t_eff   = init ? CL_ANGLE : top_ff;
      depth_in = d_eff;
      top_in   = t_eff;
      op_res  = GO_ON;
      wr_en   = 1'b0;
      rd_en   = 1'b0;
      wr_addr = STACK_ADDR_W'(d_eff - DEPTH_W'(1));
      rd_addr = STACK_ADDR_W'(d_eff - DEPTH_W'(3));
      case (op)
         OP_PUSH: begin
            if (d_eff >= DEPTH_W'(STACK_DEPTH)) begin
               op_res = GO_REJECT;
            end else begin
               wr_en    = 1'b1;
               top_in   = op_code;
               depth_in = d_eff + DEPTH_W'(1);
            end
         end
         OP_CLOSE: begin
            if (d_eff == '0) begin
               op_res = GO_REJECT;
            end else if (op_code == CL_BRACE && t_eff == CL_INTERP) begin
               rd_en    = 1'b1;
               top_in   = below_ff;
               depth_in = d_eff - DEPTH_W'(1);
               quote_in = Q_BACK;
            end else if (t_eff != op_code) begin
               op_res = GO_REJECT;
            end else begin
               rd_en    = 1'b1;
               top_in   = below_ff;
               depth_in = d_eff - DEPTH_W'(1);
               if (d_eff == DEPTH_W'(1)) begin
                  op_res = GO_ACCEPT;
               end
            end
         end
         default: ;
      endcase
      if (res == GO_ON && op_res != GO_ON) begin
         res = op_res;
      end

      // Item effects that follow a settled angle bracket.
      if (item_late && res == GO_ON) begin
         length_in = item_length;
         quote_in  = item_quote;
         defer_in  = item_defer;
         if (item_reject) begin
            res = GO_REJECT;
         end
      end

      if (clear) begin
         depth_in = '0;
      end

      emit    = (res != GO_ON);
      consume = !(split && res == GO_ON);
      if (emit) begin
         phase_in = PH_DONE;
         defer_in = D_NONE;
      end

      rsp.accepted       = (res == GO_ACCEPT);
      rsp.group_length   = (res == GO_ACCEPT) ? length_in : '0;
      rsp.blanks_skipped = (res == GO_ACCEPT) ? blank_in : '0;
   end

   assign item_pop = fire && consume;
   assign rsp_push = fire && emit;
   assign status   = '{fire: fire, consume: consume, emit: emit, depth: depth_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_DONE;
         quote_ff  <= Q_NONE;
         defer_ff  <= D_NONE;
         depth_ff  <= '0;
         length_ff <= '0;
         blank_ff  <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         quote_ff  <= quote_in;
         defer_ff  <= defer_in;
         depth_ff  <= depth_in;
         length_ff <= length_in;
         blank_ff  <= blank_in;
      end
   end

   // The top entry lives in top_ff; the memory holds the entries below it,
   // and below_ff keeps the entry just under the top ready for a pop.
   always_ff @(posedge clock) begin
      if (fire) begin
         top_ff <= top_in;
         if (wr_en) begin
            stack_mem[wr_addr] <= t_eff;
            below_ff           <= t_eff;
         end else if (rd_en) begin
            below_ff <= stack_mem[rd_addr];
         end
      end
   end

endmodule

`default_nettype wire

// ----- sv/nags_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// Nested angle group scanner result queue
// Two-entry queue that holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
`default_nettype none

module nags_rsp_queue
   import nags_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type wr_data,
   output logic    full,
   output logic    empty,
   output rsp_type rd_data,
   input  logic    pop
);

   rsp_type    data_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   always_comb begin
      full      = (count_ff == 2'd2);
      empty     = (count_ff == 2'd0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
      rd_data = data_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- sv/nested_angle_group_scanner.sv -----
// ----------------------------------------------------------------------------
// Nested angle group scanner
// Takes one character per transaction and gives at most one result per scan:
// accepted with the group length and leading blank count, or rejected. The
// block sustains one character per clock while the result queue has room.
// Each character is registered in the item queue, settled by the scanner
// from there, and its result is registered in the result queue. A bracket
// character that directly follows a '<' or '>' whose meaning was still open
// is held in the item queue and taken again, because the closer stack memory
// has a single write port and only the entry under the top is prefetched. The
// stack needs no clearing after reset, so the block is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nested_angle_group_scanner_assert.svh"

module nested_angle_group_scanner
   import nags_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [CHAR_W-1:0]  req_character,
   input  logic               req_start_scan,
   input  logic               req_token_wanted,
   input  logic               req_end_of_input,
   output logic               empty,
   input  logic               pop,
   output logic               rsp_accepted,
   output logic [COUNT_W-1:0] rsp_group_length,
   output logic [COUNT_W-1:0] rsp_blanks_skipped
);

   item_type        front_item;
   item_type        queue_item;
   logic            queue_valid;
   logic            queue_pop;
   logic            rsp_full;
   logic            rsp_push;
   rsp_type         rsp_data;
   rsp_type         rsp_head;
   back_status_type back_status;

   nags_front u_front (
      .character    (req_character),
      .start_scan   (req_start_scan),
      .token_wanted (req_token_wanted),
      .end_of_input (req_end_of_input),
      .item         (front_item)
   );

   nags_item_queue u_item_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (front_item),
      .full    (full),
      .valid   (queue_valid),
      .rd_data (queue_item),
      .pop     (queue_pop)
   );

   nags_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item       (queue_item),
      .item_pop   (queue_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp        (rsp_data),
      .status     (back_status)
   );

   nags_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_data),
      .full    (rsp_full),
      .empty   (empty),
      .rd_data (rsp_head),
      .pop     (pop)
   );

   assign rsp_accepted       = rsp_head.accepted;
   assign rsp_group_length   = rsp_head.group_length;
   assign rsp_blanks_skipped = rsp_head.blanks_skipped;

   `NAGS_ASSERT_ALWAYS(a_depth_bound, back_status.depth <= DEPTH_W'(STACK_DEPTH))
   `NAGS_ASSERT_IMPL(a_split_silent, back_status.fire && !back_status.consume, !back_status.emit)
   `NAGS_ASSERT_IMPL(a_reject_zero, rsp_push && !rsp_data.accepted, rsp_data.group_length == '0 && rsp_data.blanks_skipped == '0)
   `NAGS_ASSERT_IMPL(a_accept_length, rsp_push && rsp_data.accepted, rsp_data.group_length >= COUNT_W'(2))

endmodule

`default_nettype wire
